### hdl/ihex_pkg.sv
// ============================================================================
// ihex_pkg
// Shared types, constants and the microcode program of the Intel HEX
// record encoder.
// ============================================================================
package ihex_pkg;

  // Record geometry and field widths.
  localparam int RecordBytes = 16;
  localparam int CountW      = $clog2(RecordBytes + 1);
  localparam int IdxW        = (RecordBytes > 1) ? $clog2(RecordBytes) : 1;
  localparam int AddrW       = 16;
  localparam int ByteW       = 8;
  localparam int CharW       = 7;
  localparam int StepW       = 5;
  localparam int CfgIdxW     = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgStartAddr = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEndAddr   = 2'd1;

  // Fixed characters.
  localparam logic [CharW-1:0] AsciiColon   = 7'h3A;
  localparam logic [CharW-1:0] AsciiNewline = 7'h0A;

  // Character source of one microcode step.
  typedef enum logic [2:0] {
    CH_NONE,
    CH_COLON,
    CH_NEWLINE,
    CH_HEX_HI,
    CH_HEX_LO
  } ch_sel_t;

  // Byte operand that a hex pair is formed from.
  typedef enum logic [2:0] {
    OP_ZERO,
    OP_ONE,
    OP_FF,
    OP_COUNT,
    OP_ADDR_HI,
    OP_ADDR_LO,
    OP_DATA,
    OP_CSUM
  } op_sel_t;

  // Datapath action taken when a step fires.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SUM_CLR,
    ACT_SUM_ADD,
    ACT_SUM_ADD_NEXT,
    ACT_REC_DONE,
    ACT_RESTART
  } act_t;

  // Jump condition: when true, the step counter loads the target.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_DATA_DUE,
    C_NOT_LAST,
    C_MORE_DATA
  } cond_t;

  // Source of the run_last flag of an emitted character.
  typedef enum logic [1:0] {
    L_NO,
    L_YES,
    L_IF_NOT_LAST
  } last_sel_t;

  // One control word of the program.
  typedef struct packed {
    logic             rdy;
    ch_sel_t          ch;
    op_sel_t          op;
    act_t             act;
    cond_t            cond;
    last_sel_t        lst;
    logic [StepW-1:0] target;
  } ctrl_t;

  // Status flags that the datapath reports to the sequencer.
  typedef struct packed {
    logic data_due;
    logic last;
    logic more_data;
  } dp_stat_t;

  // Entry points of the program.
  localparam logic [StepW-1:0] StepIdle   = 5'd0;
  localparam logic [StepW-1:0] StepChkEof = 5'd2;
  localparam logic [StepW-1:0] StepRec    = 5'd15;
  localparam logic [StepW-1:0] StepData   = 5'd24;

  // Uppercase ASCII hex digit of a nibble.
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] v;
    v = {3'b000, nib};
    return (nib < 4'd10) ? (v + 7'h30) : (v + 7'h37);
  endfunction

  // Packs the fields of one control word.
  function automatic ctrl_t cw(input logic rdy, input ch_sel_t ch, input op_sel_t op,
                               input act_t act, input cond_t cond, input last_sel_t lst,
                               input logic [StepW-1:0] target);
    ctrl_t w;
    w.rdy    = rdy;
    w.ch     = ch;
    w.op     = op;
    w.act    = act;
    w.cond   = cond;
    w.lst    = lst;
    w.target = target;
    return w;
  endfunction

  // Microcode ROM.
  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t w;
    case (step)
      // Wait for an input transaction, then decide what to emit.
      5'd0:  w = cw(1'b1, CH_NONE, OP_ZERO, ACT_NONE, C_NO_ACCEPT, L_NO, StepIdle);
      5'd1:  w = cw(1'b0, CH_NONE, OP_ZERO, ACT_NONE, C_DATA_DUE, L_NO, StepRec);
      5'd2:  w = cw(1'b0, CH_NONE, OP_ZERO, ACT_NONE, C_NOT_LAST, L_NO, StepIdle);
      // End-of-file record.
      5'd3:  w = cw(1'b0, CH_COLON, OP_ZERO, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd4:  w = cw(1'b0, CH_HEX_HI, OP_ZERO, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd5:  w = cw(1'b0, CH_HEX_LO, OP_ZERO, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd6:  w = cw(1'b0, CH_HEX_HI, OP_ZERO, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd7:  w = cw(1'b0, CH_HEX_LO, OP_ZERO, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd8:  w = cw(1'b0, CH_HEX_HI, OP_ZERO, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd9:  w = cw(1'b0, CH_HEX_LO, OP_ZERO, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd10: w = cw(1'b0, CH_HEX_HI, OP_ONE, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd11: w = cw(1'b0, CH_HEX_LO, OP_ONE, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd12: w = cw(1'b0, CH_HEX_HI, OP_FF, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd13: w = cw(1'b0, CH_HEX_LO, OP_FF, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd14: w = cw(1'b0, CH_NEWLINE, OP_ZERO, ACT_RESTART, C_ALWAYS, L_YES, StepIdle);
      // Data record: header.
      5'd15: w = cw(1'b0, CH_COLON, OP_ZERO, ACT_SUM_CLR, C_NEVER, L_NO, StepIdle);
      5'd16: w = cw(1'b0, CH_HEX_HI, OP_COUNT, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd17: w = cw(1'b0, CH_HEX_LO, OP_COUNT, ACT_SUM_ADD, C_NEVER, L_NO, StepIdle);
      5'd18: w = cw(1'b0, CH_HEX_HI, OP_ADDR_HI, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd19: w = cw(1'b0, CH_HEX_LO, OP_ADDR_HI, ACT_SUM_ADD, C_NEVER, L_NO, StepIdle);
      5'd20: w = cw(1'b0, CH_HEX_HI, OP_ADDR_LO, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd21: w = cw(1'b0, CH_HEX_LO, OP_ADDR_LO, ACT_SUM_ADD, C_NEVER, L_NO, StepIdle);
      5'd22: w = cw(1'b0, CH_HEX_HI, OP_ZERO, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd23: w = cw(1'b0, CH_HEX_LO, OP_ZERO, ACT_NONE, C_NEVER, L_NO, StepIdle);
      // Data record: payload loop, checksum and line end.
      5'd24: w = cw(1'b0, CH_HEX_HI, OP_DATA, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd25: w = cw(1'b0, CH_HEX_LO, OP_DATA, ACT_SUM_ADD_NEXT, C_MORE_DATA, L_NO,
                    StepData);
      5'd26: w = cw(1'b0, CH_HEX_HI, OP_CSUM, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd27: w = cw(1'b0, CH_HEX_LO, OP_CSUM, ACT_NONE, C_NEVER, L_NO, StepIdle);
      5'd28: w = cw(1'b0, CH_NEWLINE, OP_ZERO, ACT_REC_DONE, C_ALWAYS, L_IF_NOT_LAST,
                    StepChkEof);
      default: w = cw(1'b0, CH_NONE, OP_ZERO, ACT_NONE, C_ALWAYS, L_NO, StepIdle);
    endcase
    return w;
  endfunction

endpackage

### hdl/ihex_if.sv
// ============================================================================
// ihex_if
// Valid/ready channel interfaces for the input bytes and the output text.
// ============================================================================

// Input channel: one image byte or end marker per transaction.
interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       stream_end;

  modport source (output valid, output data_byte, output byte_present,
                  output stream_end, input ready);
  modport sink (input valid, input data_byte, input byte_present,
                input stream_end, output ready);
endinterface

// Output channel: one ASCII character per transaction.
interface ihex_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] text_char;
  logic       run_last;

  modport source (output valid, output text_char, output run_last, input ready);
  modport sink (input valid, input text_char, input run_last, output ready);
endinterface

### hdl/ihex_seq.sv
// ============================================================================
// ihex_seq
// Microcode sequencer: step counter, control ROM and jump logic.
// ============================================================================
module ihex_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              slot_free,
  input  ihex_pkg::dp_stat_t stat,
  output ihex_pkg::ctrl_t   ctrl,
  output logic              fire,
  output logic              accept
);
  import ihex_pkg::*;

  logic [StepW-1:0] step_r;
  logic [StepW-1:0] step_nxt;
  logic             take;

  // Control word of the current step.
  assign ctrl   = ucode(step_r);
  assign accept = ctrl.rdy & in_valid;

  // A step that emits a character waits for a free output register.
  assign fire = (ctrl.ch == CH_NONE) | slot_free;

  // Jump condition and next step.
  always_comb begin
    case (ctrl.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_ACCEPT: take = ~accept;
      C_DATA_DUE:  take = stat.data_due;
      C_NOT_LAST:  take = ~stat.last;
      C_MORE_DATA: take = stat.more_data;
      default:     take = 1'b1;
    endcase
    step_nxt = step_r;
    if (fire) begin
      step_nxt = take ? ctrl.target : step_r + StepW'(1);
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= StepIdle;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### hdl/ihex_dp.sv
// ============================================================================
// ihex_dp
// Encoder datapath: configuration registers, record buffer, address and
// count registers, checksum accumulator and the output character register.
// ============================================================================
module ihex_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ihex_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ihex_pkg::AddrW-1:0]   cfg_wdata,
  input  logic                         accept,
  input  logic [ihex_pkg::ByteW-1:0]   in_data_byte,
  input  logic                         in_byte_present,
  input  logic                         in_stream_end,
  input  ihex_pkg::ctrl_t              ctrl,
  input  logic                         fire,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [ihex_pkg::CharW-1:0]   out_text_char,
  output logic                         out_run_last,
  output logic                         slot_free,
  output ihex_pkg::dp_stat_t           stat
);
  import ihex_pkg::*;

  logic [AddrW-1:0]  start_r, start_nxt;
  logic [AddrW-1:0]  end_r, end_nxt;
  logic [ByteW-1:0]  buf_r [RecordBytes];
  logic [CountW-1:0] count_r, count_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic [AddrW-1:0]  bytes_r, bytes_nxt;
  logic [AddrW-1:0]  addr_r, addr_nxt;
  logic [ByteW-1:0]  sum_r, sum_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CharW-1:0]  out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic [AddrW-1:0]  limit;
  logic              take_byte;
  logic [ByteW-1:0]  op_val;
  logic [CharW-1:0]  char_val;
  logic              last_val;
  logic              emit;
  logic              act_fire_done;
  logic              act_fire_restart;

  // Byte limit of the stream and the acceptance test for one byte.
  assign limit     = (end_r > start_r) ? (end_r - start_r) : '0;
  assign take_byte = accept & in_byte_present & (bytes_r < limit) &
                     (count_r < CountW'(RecordBytes));

  // Operand of the current hex pair.
  always_comb begin
    case (ctrl.op)
      OP_ZERO:    op_val = 8'h00;
      OP_ONE:     op_val = 8'h01;
      OP_FF:      op_val = 8'hFF;
      OP_COUNT:   op_val = ByteW'(count_r);
      OP_ADDR_HI: op_val = addr_r[15:8];
      OP_ADDR_LO: op_val = addr_r[7:0];
      OP_DATA:    op_val = buf_r[idx_r];
      OP_CSUM:    op_val = ~sum_r + 8'd1;
      default:    op_val = 8'h00;
    endcase
  end

  // Character and run_last flag of the current step.
  always_comb begin
    case (ctrl.ch)
      CH_COLON:   char_val = AsciiColon;
      CH_NEWLINE: char_val = AsciiNewline;
      CH_HEX_HI:  char_val = hex_char(op_val[7:4]);
      CH_HEX_LO:  char_val = hex_char(op_val[3:0]);
      default:    char_val = '0;
    endcase
    case (ctrl.lst)
      L_YES:         last_val = 1'b1;
      L_IF_NOT_LAST: last_val = ~last_r;
      default:       last_val = 1'b0;
    endcase
  end

  assign emit             = fire & (ctrl.ch != CH_NONE);
  assign act_fire_done    = fire & (ctrl.act == ACT_REC_DONE);
  assign act_fire_restart = fire & (ctrl.act == ACT_RESTART);

  // Next values of the control and working registers.
  always_comb begin
    start_nxt     = start_r;
    end_nxt       = end_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    bytes_nxt     = bytes_r;
    addr_nxt      = addr_r;
    sum_nxt       = sum_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    // Configuration writes; a new start address loads at once on an idle stream.
    if (cfg_we) begin
      case (cfg_index)
        CfgStartAddr: begin
          start_nxt = cfg_wdata;
          if ((bytes_r == '0) && (count_r == '0)) begin
            addr_nxt = cfg_wdata;
          end
        end
        CfgEndAddr: end_nxt = cfg_wdata;
        default: ;
      endcase
    end

    // Input transaction.
    if (accept) begin
      last_nxt = in_stream_end;
    end
    if (take_byte) begin
      count_nxt = count_r + CountW'(1);
      bytes_nxt = bytes_r + AddrW'(1);
    end

    // Microcode actions.
    if (fire) begin
      case (ctrl.act)
        ACT_SUM_CLR:  sum_nxt = '0;
        ACT_SUM_ADD:  sum_nxt = sum_r + op_val;
        ACT_SUM_ADD_NEXT: begin
          sum_nxt = sum_r + op_val;
          idx_nxt = idx_r + IdxW'(1);
        end
        ACT_REC_DONE: begin
          addr_nxt  = addr_r + AddrW'(count_r);
          count_nxt = '0;
          idx_nxt   = '0;
        end
        ACT_RESTART: begin
          addr_nxt  = start_r;
          count_nxt = '0;
          bytes_nxt = '0;
          idx_nxt   = '0;
        end
        default: ;
      endcase
    end

    // Output register.
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = char_val;
      out_last_nxt  = last_val;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      end_r       <= '1;
      count_r     <= '0;
      idx_r       <= '0;
      bytes_r     <= '0;
      addr_r      <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      bytes_r     <= bytes_nxt;
      addr_r      <= addr_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Record buffer, written at the fill position.
  always_ff @(posedge clk) begin
    if (take_byte) begin
      buf_r[count_r[IdxW-1:0]] <= in_data_byte;
    end
  end

  // Status to the sequencer.
  assign stat.data_due  = (count_r == CountW'(RecordBytes)) | (last_r & (count_r != '0));
  assign stat.last      = last_r;
  assign stat.more_data = (CountW'(idx_r) + CountW'(1)) != count_r;

  assign slot_free     = ~out_valid_r | out_ready;
  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_run_last  = out_last_r;

  // The buffer never holds more than one record.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CountW'(RecordBytes))
    else $error("record buffer count exceeds record size");

  // A data record starts only with bytes in the buffer.
  a_rec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ctrl.act == ACT_SUM_CLR) |-> (count_r != '0))
    else $error("data record started on an empty buffer");

  // The end-of-file record leaves the stream restarted.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    act_fire_restart |=> (count_r == '0) && (bytes_r == '0) && (addr_r == $past(start_r)))
    else $error("stream not restarted after end-of-file record");

  // A record line end empties the buffer and advances the address.
  a_rec_done: assert property (@(posedge clk) disable iff (!rst_n)
    act_fire_done |=> (count_r == '0) && (addr_r == $past(addr_r) + AddrW'($past(count_r))))
    else $error("record completion did not update count and address");

endmodule

### hdl/intel_hex_text_encoder_core.sv
// ============================================================================
// intel_hex_text_encoder_core
// Intel HEX text encoder: image bytes in, one ASCII character out per
// transaction.
// ============================================================================
// Bytes are collected into a 16-byte record buffer; a full buffer, or a
// transaction with stream_end set on a non-empty buffer, makes the
// encoder write a type-00 data record (colon, count, address, type, data,
// checksum, newline), and stream_end then adds the end-of-file record and
// restarts the address at start_address. Input is taken only while the
// sequencer sits in its idle step, so the block takes no new transaction
// until its sequencer has emitted all text that the last one caused. The
// microcode step counter emits at most one character per step through a
// single output register, and any stall on the output side holds it.
module intel_hex_text_encoder_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ihex_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ihex_pkg::AddrW-1:0]   cfg_wdata,
  ihex_in_if.sink                      in_ch,
  ihex_out_if.source                   out_ch
);
  import ihex_pkg::*;

  ctrl_t    ctrl;
  dp_stat_t stat;
  logic     fire;
  logic     accept;
  logic     slot_free;

  // Sequencer.
  ihex_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .slot_free (slot_free),
    .stat      (stat),
    .ctrl      (ctrl),
    .fire      (fire),
    .accept    (accept)
  );

  assign in_ch.ready = ctrl.rdy;

  // Datapath.
  ihex_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .accept          (accept),
    .in_data_byte    (in_ch.data_byte),
    .in_byte_present (in_ch.byte_present),
    .in_stream_end   (in_ch.stream_end),
    .ctrl            (ctrl),
    .fire            (fire),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_text_char   (out_ch.text_char),
    .out_run_last    (out_ch.run_last),
    .slot_free       (slot_free),
    .stat            (stat)
  );

endmodule

### test/intel_hex_text_encoder_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// intel_hex_text_encoder_core_tb
// Self-checking bench for the Intel HEX text encoder core.
// ============================================================================
// Image bytes are sent through the input channel and the ASCII text that
// comes back is checked character by character against a behavioral
// encoder kept inside the bench. A directed opening covers empty streams,
// ignored transactions, address wrap, a zero limit and unused register
// indexes. Random streams with random address windows, stalls and gaps
// on both channels follow.
// ============================================================================
module intel_hex_text_encoder_core_tb;
  import ihex_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 8;
  localparam int DrainCycles   = 64;
  localparam int RandomItems   = 140;

  // Register indexes that decode to nothing.
  localparam logic [CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare3 = 2'd3;

  // Intel HEX record types.
  localparam logic [ByteW-1:0] RecTypeData = 8'h00;
  localparam logic [ByteW-1:0] RecTypeEof  = 8'h01;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             byte_present;
    logic             stream_end;
  } image_item_t;

  typedef struct packed {
    logic [CharW-1:0] text_char;
    logic             run_last;
  } text_beat_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [AddrW-1:0]    cfg_wdata;

  ihex_in_if  in_ch ();
  ihex_out_if out_ch ();

  intel_hex_text_encoder_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Encoder state as the bench predicts it.
  logic [AddrW-1:0]  enc_start;
  logic [AddrW-1:0]  enc_end;
  logic [AddrW-1:0]  enc_rec_addr;
  logic [AddrW-1:0]  enc_taken;
  logic [CountW-1:0] enc_fill;
  logic [ByteW-1:0]  enc_buf [RecordBytes];

  image_item_t byte_queue [$];
  text_beat_t  text_expected [$];
  image_item_t drive_item;
  image_item_t taken_item;
  text_beat_t  want_beat;

  int  err_cnt        = 0;
  int  chars_checked  = 0;
  int  items_taken    = 0;
  int  useful_items   = 0;
  int  records_made   = 0;
  int  streams_closed = 0;
  int  in_gap;
  int  out_stall;
  int  quiet_cycles;
  bit  no_idle        = 1'b0;

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length for either channel: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Uppercase hex digit of a nibble.
  function automatic logic [CharW-1:0] nibble_char(input logic [3:0] nib);
    if (nib < 4'd10) return 7'h30 + {3'b000, nib};
    return 7'h41 + {3'b000, nib} - 7'd10;
  endfunction

  task automatic expect_char(input logic [CharW-1:0] c);
    text_beat_t b;
    b.text_char = c;
    b.run_last  = 1'b0;
    text_expected.push_back(b);
  endtask

  task automatic expect_hex_byte(input logic [ByteW-1:0] v);
    expect_char(nibble_char(v[7:4]));
    expect_char(nibble_char(v[3:0]));
  endtask

  // Data record built from the buffered bytes; advances the load address.
  task automatic expect_data_record();
    logic [ByteW-1:0] sum;
    int               i;
    sum = {3'b000, enc_fill} + enc_rec_addr[15:8] + enc_rec_addr[7:0];
    expect_char(AsciiColon);
    expect_hex_byte({3'b000, enc_fill});
    expect_hex_byte(enc_rec_addr[15:8]);
    expect_hex_byte(enc_rec_addr[7:0]);
    expect_hex_byte(RecTypeData);
    for (i = 0; i < enc_fill; i++) begin
      expect_hex_byte(enc_buf[i]);
      sum = sum + enc_buf[i];
    end
    expect_hex_byte(8'h00 - sum);
    expect_char(AsciiNewline);
    enc_rec_addr = enc_rec_addr + {11'b0, enc_fill};
    enc_fill     = '0;
    records_made++;
  endtask

  // End-of-file record: no data, address zero, type 01.
  task automatic expect_eof_record();
    expect_char(AsciiColon);
    expect_hex_byte(8'h00);
    expect_hex_byte(8'h00);
    expect_hex_byte(8'h00);
    expect_hex_byte(RecTypeEof);
    expect_hex_byte(8'h00 - RecTypeEof);
    expect_char(AsciiNewline);
  endtask

  // Works out the text caused by one accepted input transaction.
  task automatic encode_item(input image_item_t it);
    logic [AddrW-1:0] room;
    int               first_new;
    bit               had_effect;
    text_beat_t       tail;
    first_new  = text_expected.size();
    had_effect = 1'b0;
    room       = (enc_end > enc_start) ? enc_end - enc_start : '0;
    if (it.byte_present && enc_taken < room && enc_fill < RecordBytes) begin
      enc_buf[enc_fill[IdxW-1:0]] = it.data_byte;
      enc_fill   = enc_fill + 1'b1;
      enc_taken  = enc_taken + 1'b1;
      had_effect = 1'b1;
      if (enc_fill == RecordBytes) expect_data_record();
    end
    if (it.stream_end) begin
      if (enc_fill != 0) expect_data_record();
      expect_eof_record();
      enc_fill     = '0;
      enc_taken    = '0;
      enc_rec_addr = enc_start;
      had_effect   = 1'b1;
      streams_closed++;
    end
    if (had_effect) useful_items++;
    // The last character of this transaction carries run_last.
    if (text_expected.size() > first_new) begin
      tail = text_expected.pop_back();
      tail.run_last = 1'b1;
      text_expected.push_back(tail);
    end
  endtask

  // Register write, driven with nonblocking assignments; the caller lowers cfg_we.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CfgStartAddr: begin
        enc_start = val;
        if (enc_taken == 0 && enc_fill == 0) enc_rec_addr = val;
      end
      CfgEndAddr: enc_end = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic add_item(input logic [ByteW-1:0] d, input logic present, input logic last);
    image_item_t it;
    it.data_byte    = d;
    it.byte_present = present;
    it.stream_end   = last;
    byte_queue.push_back(it);
  endtask

  // A stream of random bytes with the odd ignored transaction mixed in.
  task automatic add_stream(input int n_bytes, input bit close);
    int i;
    for (i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 99) < 8) add_item(ByteW'($urandom_range(0, 255)), 1'b0, 1'b0);
      add_item(ByteW'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
    if (close) add_item(ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Random address window, extremes and empty windows included.
  task automatic random_config();
    logic [AddrW-1:0] s;
    logic [AddrW-1:0] e;
    int               pick;
    case ($urandom_range(0, 6))
      0: begin s = '0; e = 16'hFFFF; end
      1: begin
        s = AddrW'($urandom_range(0, 16'hFFFF));
        e = s + AddrW'($urandom_range(1, 40));
      end
      2: begin s = 16'hFFFF; e = '0; end
      3: begin s = AddrW'($urandom_range(0, 16'hFFFF)); e = 16'hFFFF; end
      4: begin
        s = AddrW'($urandom_range(0, 16'hFFFF));
        e = AddrW'($urandom_range(0, 16'hFFFF));
      end
      5: begin s = 16'hFFD0 + AddrW'($urandom_range(0, 15)); e = 16'hFFFF; end
      default: begin
        s = AddrW'($urandom_range(0, 255));
        e = s + AddrW'($urandom_range(0, 3));
      end
    endcase
    if ($urandom_range(0, 6) == 0) begin
      cfg_write($urandom_range(0, 1) ? CfgSpare2 : CfgSpare3,
                AddrW'($urandom_range(0, 16'hFFFF)));
    end
    pick = $urandom_range(0, 9);
    if (pick != 9) cfg_write(CfgStartAddr, s);
    if (pick != 8) cfg_write(CfgEndAddr, e);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued transaction is in and all text is out.
  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_ch.valid || text_expected.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Input driver: presents queued items with random gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap      <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap      <= in_gap - 1;
      end else if (byte_queue.size() != 0) begin
        drive_item          = byte_queue.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= drive_item.data_byte;
        in_ch.byte_present <= drive_item.byte_present;
        in_ch.stream_end   <= drive_item.stream_end;
        in_gap             <= pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Output back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall    <= out_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      out_stall    <= pick_gap();
    end
  end

  // Monitor: predicts on each input transaction, checks each output one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        taken_item.data_byte    = in_ch.data_byte;
        taken_item.byte_present = in_ch.byte_present;
        taken_item.stream_end   = in_ch.stream_end;
        encode_item(taken_item);
        items_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (text_expected.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected character: expected none, actual %h (run_last %b)",
                   $time, out_ch.text_char, out_ch.run_last);
        end else begin
          want_beat = text_expected.pop_front();
          chars_checked++;
          if (out_ch.text_char !== want_beat.text_char) begin
            err_cnt++;
            $display("%0t: text_char mismatch: expected %h, actual %h",
                     $time, want_beat.text_char, out_ch.text_char);
          end
          if (out_ch.run_last !== want_beat.run_last) begin
            err_cnt++;
            $display("%0t: run_last mismatch: expected %b, actual %b",
                     $time, want_beat.run_last, out_ch.run_last);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
      $display("intel_hex_text_encoder_core_tb: errors");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int n_streams;
    int len;
    int base;
    int k;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    enc_start          = '0;
    enc_end            = 16'hFFFF;
    enc_rec_addr       = '0;
    enc_taken          = '0;
    enc_fill           = '0;
    for (k = 0; k < RecordBytes; k++) enc_buf[k] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window: ignored transaction, empty stream, short stream closed by a byte.
    add_item(8'h00, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hFF, 1'b1, 1'b0);
    add_item(8'hA5, 1'b1, 1'b1);
    wait_idle();

    // Window at the top of memory; moving the start mid-stream lifts the limit
    // but keeps the load address, so the address after the full record wraps to zero.
    cfg_write(CfgStartAddr, 16'hFFF0);
    cfg_write(CfgEndAddr, 16'hFFFF);
    cfg_we <= 1'b0;
    for (k = 0; k < 8; k++) add_item(ByteW'($urandom_range(0, 255)), 1'b1, 1'b0);
    wait_idle();
    cfg_write(CfgStartAddr, 16'h0000);
    cfg_we <= 1'b0;
    for (k = 0; k < 9; k++) add_item(ByteW'($urandom_range(0, 255)), 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    wait_idle();

    // Unused register indexes, then an empty window: every byte is dropped.
    cfg_write(CfgSpare2, AddrW'($urandom_range(0, 16'hFFFF)));
    cfg_write(CfgSpare3, AddrW'($urandom_range(0, 16'hFFFF)));
    cfg_write(CfgStartAddr, 16'hFFFF);
    cfg_write(CfgEndAddr, 16'h0000);
    cfg_we <= 1'b0;
    add_item(8'h5A, 1'b1, 1'b0);
    add_item(8'h3C, 1'b1, 1'b1);
    wait_idle();

    // Random phases: new window, a few streams, sometimes one left open.
    base = items_taken;
    while (items_taken - base < RandomItems) begin
      no_idle = ($urandom_range(0, 3) == 0);
      random_config();
      n_streams = $urandom_range(1, 3);
      for (k = 0; k < n_streams; k++) begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 20) : $urandom_range(21, 50);
        add_stream(len, (k < n_streams - 1) || ($urandom_range(0, 4) != 0));
      end
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d input transactions (%0d with an effect) in %0d closed streams, %0d data records.",
             items_taken, useful_items, streams_closed, records_made);
    $display("Compared %0d characters, %0d mismatches.", chars_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("intel_hex_text_encoder_core_tb: clean");
    end else begin
      $display("intel_hex_text_encoder_core_tb: errors");
    end
    $finish;
  end

endmodule
